### rtl/kct_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// kct_pkg: shared constants, request/response types and the cell chain type
// for the key cache table. No dependencies.

package kct_pkg;

    // store geometry
    localparam int CACHE_ENTRIES = 16;
    localparam int KEY_WORDS     = 4;
    localparam int KEY_BITS      = 64;
    localparam int ID_BITS       = 32;
    localparam int VER_BITS      = 32;

    // operation codes
    localparam logic [1:0] OP_LOOKUP = 2'd0;
    localparam logic [1:0] OP_INSERT = 2'd1;
    localparam logic [1:0] OP_FLUSH  = 2'd2;

    // status codes
    localparam logic ST_OK   = 1'b0;
    localparam logic ST_FULL = 1'b1;

    typedef logic [KEY_WORDS-1:0][KEY_BITS-1:0] t_kct_key;

    // request payload
    typedef struct packed {
        logic [1:0]          operation;
        logic [ID_BITS-1:0]  space_id;
        logic [KEY_BITS-1:0] key_word0;
        logic [KEY_BITS-1:0] key_word1;
        logic [KEY_BITS-1:0] key_word2;
        logic [KEY_BITS-1:0] key_word3;
        logic [VER_BITS-1:0] key_version;
        logic                entry_active;
    } t_kct_req;

    // response payload
    typedef struct packed {
        logic                hit;
        logic [KEY_BITS-1:0] found_key0;
        logic [KEY_BITS-1:0] found_key1;
        logic [KEY_BITS-1:0] found_key2;
        logic [KEY_BITS-1:0] found_key3;
        logic [VER_BITS-1:0] found_version;
        logic                status;
    } t_kct_rsp;

    // carried from cell to cell: what lower slots have already claimed
    typedef struct packed {
        logic                seen_match;
        logic                seen_hit;
        logic                seen_inact;
        logic                all_used;
        t_kct_key            key;
        logic [VER_BITS-1:0] version;
    } t_kct_chain;

    // write decision broadcast to every cell
    typedef struct packed {
        logic flush;
        logic we_upd;
        logic we_app;
        logic we_reuse;
    } t_kct_ctl;

    // key words of a request that the store keeps
    function automatic t_kct_key kct_key_of(input t_kct_req req);
        t_kct_key k;
        k = '0;
        for (int w = 0; w < KEY_WORDS; w++) begin
            case (w)
                0: k[w] = req.key_word0;
                1: k[w] = req.key_word1;
                2: k[w] = req.key_word2;
                3: k[w] = req.key_word3;
                default: k[w] = '0;
            endcase
        end
        return k;
    endfunction

endpackage

`default_nettype wire

### rtl/kct_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// kct_cell: one slot of the key cache, holding id, key, version and marks,
// and passing its claim and hit data to the next slot. Depends on kct_pkg.

module kct_cell
    import kct_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_kct_req   i_req,
    input  wire t_kct_key   i_key,
    input  wire t_kct_ctl   i_ctl,
    input  wire t_kct_chain i_chain,
    output t_kct_chain      o_chain
);

    logic                r_used;
    logic                r_act;
    logic [ID_BITS-1:0]  r_id;
    t_kct_key            r_key;
    logic [VER_BITS-1:0] r_ver;

    logic match;
    logic sel_upd;
    logic sel_hit;
    logic sel_inact;
    logic sel_app;
    logic we;

    // slot compare and first-claim selects
    assign match     = r_used && (r_id == i_req.space_id);
    assign sel_upd   = match && !i_chain.seen_match;
    assign sel_hit   = match && r_act && !i_chain.seen_hit;
    assign sel_inact = r_used && !r_act && !i_chain.seen_inact;
    assign sel_app   = !r_used && i_chain.all_used;

    // hand claims and hit data to the next slot
    always_comb begin
        o_chain.seen_match = i_chain.seen_match || match;
        o_chain.seen_hit   = i_chain.seen_hit || (match && r_act);
        o_chain.seen_inact = i_chain.seen_inact || (r_used && !r_act);
        o_chain.all_used   = i_chain.all_used && r_used;
        o_chain.key        = i_chain.key | (sel_hit ? r_key : '0);
        o_chain.version    = i_chain.version | (sel_hit ? r_ver : '0);
    end

    assign we = (i_ctl.we_upd && sel_upd) || (i_ctl.we_app && sel_app)
             || (i_ctl.we_reuse && sel_inact);

    // occupancy and active mark
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.flush) begin
            r_used <= 1'b0;
            r_act  <= 1'b0;
        end else if (we) begin
            r_used <= 1'b1;
            r_act  <= i_req.entry_active;
        end
    end

    // slot payload
    always_ff @(posedge i_clk) begin
        if (we) begin
            r_id  <= i_req.space_id;
            r_key <= i_key;
            r_ver <= i_req.key_version;
        end
    end

endmodule

`default_nettype wire

### rtl/key_cache_table.sv
`timescale 1ns / 1ps
`default_nettype none
// key_cache_table: top level of the key cache, a row of kct_cell slots with
// request capture, write decision and response register. Depends on kct_pkg.
//
// Usage:
//   A request (lookup, insert/update or flush) is taken at a rising edge with
//   start high and busy low. The request is registered, then in the next cycle
//   every slot compares it at once and first-claim flags ripple along the row
//   of slots; the chosen slot is written and the response is registered.
//   o_valid is high for exactly one cycle, set by the response register at the
//   edge that writes the chosen slot, carrying hit, key words, version and
//   status. busy is high while a request is compared, so none is taken until it
//   is written; the ripple through the CACHE_ENTRIES slots sets the cycle length.
//   The receiver cannot stall: each response is shown for one cycle only.
//   Reset empties the store (all slots unused and inactive) and drops any
//   request in flight; no clearing pass is needed.

module key_cache_table
    import kct_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     start,
    input  wire t_kct_req i_req,
    output logic          busy,
    output logic          o_valid,
    output t_kct_rsp      o_rsp
);

    logic       r_pend;
    t_kct_req   r_req;
    logic       r_valid;
    t_kct_rsp   r_rsp;
    t_kct_rsp   n_rsp;
    t_kct_key   req_key;
    t_kct_ctl   ctl;
    t_kct_chain chain_head;
    t_kct_chain chain [CACHE_ENTRIES+1];
    t_kct_chain chain_end;
    logic       is_ins;
    logic       is_look;

    // request capture
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 1'b0;
        end else begin
            r_pend <= start && !r_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        if (start && !r_pend) begin
            r_req <= i_req;
        end
    end

    assign busy    = r_pend;
    assign req_key = kct_key_of(r_req);

    // row of slots
    always_comb begin
        chain_head          = '0;
        chain_head.all_used = 1'b1;
    end

    assign chain[0] = chain_head;

    for (genvar g = 0; g < CACHE_ENTRIES; g++) begin : g_cell
        kct_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_req   (r_req),
            .i_key   (req_key),
            .i_ctl   (ctl),
            .i_chain (chain[g]),
            .o_chain (chain[g+1])
        );
    end

    assign chain_end = chain[CACHE_ENTRIES];

    // write decision: flush, or for an insert update, append, reuse inactive, or refuse
    assign is_ins  = r_pend && (r_req.operation == OP_INSERT);
    assign is_look = r_pend && (r_req.operation == OP_LOOKUP);

    always_comb begin
        ctl.flush    = r_pend && (r_req.operation == OP_FLUSH);
        ctl.we_upd   = is_ins && chain_end.seen_match;
        ctl.we_app   = is_ins && !chain_end.seen_match && !chain_end.all_used;
        ctl.we_reuse = is_ins && !chain_end.seen_match && chain_end.all_used
                    && chain_end.seen_inact;
    end

    // response build
    always_comb begin
        n_rsp = '0;
        if (is_look && chain_end.seen_hit) begin
            n_rsp.hit           = 1'b1;
            n_rsp.found_version = chain_end.version;
            for (int w = 0; w < KEY_WORDS; w++) begin
                case (w)
                    0: n_rsp.found_key0 = chain_end.key[w];
                    1: n_rsp.found_key1 = chain_end.key[w];
                    2: n_rsp.found_key2 = chain_end.key[w];
                    3: n_rsp.found_key3 = chain_end.key[w];
                    default: ;
                endcase
            end
        end
        if (is_ins && !chain_end.seen_match && chain_end.all_used
                && !chain_end.seen_inact) begin
            n_rsp.status = ST_FULL;
        end else begin
            n_rsp.status = ST_OK;
        end
    end

    // response register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= r_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_pend) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_valid = r_valid;
    assign o_rsp   = r_rsp;

endmodule

`default_nettype wire

### test/key_cache_table_test.sv
`timescale 1ns / 1ps
// key_cache_table_test: self-checking bench for the key cache table, with a
// queue-fed request driver, a response monitor and an in-bench store model.
// Depends on kct_pkg and key_cache_table.

module key_cache_table_test;
    import kct_pkg::*;

    // the unassigned operation code, answered with all zeros
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT  = 50000;
    localparam int RANDOM_ITEMS = 600;

    logic     i_clk   = 1'b0;
    logic     i_rst_n = 1'b0;
    logic     start   = 1'b0;
    t_kct_req req_bus = '0;
    logic     busy;
    logic     o_valid;
    t_kct_rsp o_rsp;

    key_cache_table u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_req   (req_bus),
        .busy    (busy),
        .o_valid (o_valid),
        .o_rsp   (o_rsp)
    );

    // bench copy of the store
    int          used_slots;
    logic [31:0] slot_id      [CACHE_ENTRIES];
    t_kct_key    slot_key     [CACHE_ENTRIES];
    logic [31:0] slot_version [CACHE_ENTRIES];
    logic        slot_active  [CACHE_ENTRIES];

    t_kct_req pending_requests[$];
    t_kct_rsp expected_responses[$];
    logic     req_taken = 1'b0;
    int       issued    = 0;
    int       errors    = 0;
    int       cycles    = 0;

    // clock
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // empty the bench store
    function automatic void wipe_store();
        used_slots = 0;
        for (int i = 0; i < CACHE_ENTRIES; i++) begin
            slot_id[i]      = '0;
            slot_key[i]     = '0;
            slot_version[i] = '0;
            slot_active[i]  = 1'b0;
        end
    endfunction

    function automatic void store_entry(input int slot, input t_kct_req rq);
        slot_id[slot]      = rq.space_id;
        slot_key[slot][0]  = rq.key_word0;
        slot_key[slot][1]  = rq.key_word1;
        slot_key[slot][2]  = rq.key_word2;
        slot_key[slot][3]  = rq.key_word3;
        slot_version[slot] = rq.key_version;
        slot_active[slot]  = rq.entry_active;
    endfunction

    // expected response of one request, updating the bench store
    function automatic t_kct_rsp predict_response(input t_kct_req rq);
        t_kct_rsp r;
        int       n;
        int       match_slot;
        int       spare_slot;
        logic     found;
        r          = '0;
        n          = used_slots;
        match_slot = -1;
        spare_slot = -1;
        found      = 1'b0;
        case (rq.operation)
            OP_LOOKUP: begin
                for (int i = 0; i < n; i++) begin
                    if (!found && slot_id[i] == rq.space_id && slot_active[i]) begin
                        found           = 1'b1;
                        r.hit           = 1'b1;
                        r.found_key0    = slot_key[i][0];
                        r.found_key1    = slot_key[i][1];
                        r.found_key2    = slot_key[i][2];
                        r.found_key3    = slot_key[i][3];
                        r.found_version = slot_version[i];
                    end
                end
            end
            OP_INSERT: begin
                for (int i = 0; i < n; i++) begin
                    if (match_slot < 0 && slot_id[i] == rq.space_id)
                        match_slot = i;
                    if (spare_slot < 0 && !slot_active[i])
                        spare_slot = i;
                end
                if (match_slot >= 0) begin
                    store_entry(match_slot, rq);
                end else if (n < CACHE_ENTRIES) begin
                    store_entry(n, rq);
                    used_slots = n + 1;
                end else if (spare_slot >= 0) begin
                    store_entry(spare_slot, rq);
                end else begin
                    r.status = ST_FULL;
                end
            end
            OP_FLUSH: begin
                wipe_store();
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    function automatic t_kct_req make_req(input logic [1:0] op, input logic [31:0] id,
                                          input logic [63:0] fill, input logic [31:0] ver,
                                          input logic act);
        t_kct_req rq;
        rq.operation    = op;
        rq.space_id     = id;
        rq.key_word0    = fill;
        rq.key_word1    = fill;
        rq.key_word2    = fill;
        rq.key_word3    = fill;
        rq.key_version  = ver;
        rq.entry_active = act;
        return rq;
    endfunction

    // request with random key, version and active mark
    function automatic t_kct_req random_req(input logic [1:0] op, input logic [31:0] id);
        t_kct_req rq;
        rq.operation    = op;
        rq.space_id     = id;
        rq.key_word0    = {$urandom, $urandom};
        rq.key_word1    = {$urandom, $urandom};
        rq.key_word2    = {$urandom, $urandom};
        rq.key_word3    = {$urandom, $urandom};
        rq.key_version  = $urandom;
        rq.entry_active = ($urandom_range(0, 9) < 7);
        return rq;
    endfunction

    task automatic check_response(input t_kct_rsp got, input t_kct_rsp want);
        if (got.hit !== want.hit) begin
            $error("hit: expected %0h, actual %0h", want.hit, got.hit);
            errors++;
        end
        if (got.found_key0 !== want.found_key0) begin
            $error("found_key0: expected %0h, actual %0h", want.found_key0, got.found_key0);
            errors++;
        end
        if (got.found_key1 !== want.found_key1) begin
            $error("found_key1: expected %0h, actual %0h", want.found_key1, got.found_key1);
            errors++;
        end
        if (got.found_key2 !== want.found_key2) begin
            $error("found_key2: expected %0h, actual %0h", want.found_key2, got.found_key2);
            errors++;
        end
        if (got.found_key3 !== want.found_key3) begin
            $error("found_key3: expected %0h, actual %0h", want.found_key3, got.found_key3);
            errors++;
        end
        if (got.found_version !== want.found_version) begin
            $error("found_version: expected %0h, actual %0h",
                   want.found_version, got.found_version);
            errors++;
        end
        if (got.status !== want.status) begin
            $error("status: expected %0h, actual %0h", want.status, got.status);
            errors++;
        end
    endtask

    // driver: new request at the falling edge once the previous one is taken
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (!start || req_taken) begin
            if (pending_requests.size() > 0 &&
                ((issued >= 250 && issued < 400) || $urandom_range(0, 99) >= 7)) begin
                start   <= 1'b1;
                req_bus <= pending_requests.pop_front();
                issued++;
            end else begin
                start <= 1'b0;
            end
        end
    end

    // monitor: check responses, predict accepted requests, watch the limit
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("key_cache_table_test: FAIL");
            $finish;
        end
        if (!i_rst_n) begin
            req_taken <= 1'b0;
        end else begin
            if (o_valid) begin
                if (expected_responses.size() == 0) begin
                    $error("response with none expected");
                    errors++;
                end else begin
                    check_response(o_rsp, expected_responses.pop_front());
                end
            end
            req_taken <= start && !busy;
            if (start && !busy)
                expected_responses.push_back(predict_response(req_bus));
        end
    end

    // stimulus and end of run
    initial begin
        logic [31:0] id_pool[24];
        int          pool_size;
        int          run_len;
        int          rand_count;
        int          pick;

        wipe_store();

        // directed: empty miss, extremes, unused code, inactive update, flush
        pending_requests.push_back(make_req(OP_LOOKUP, 32'h0, '0, '0, 1'b0));
        pending_requests.push_back(make_req(OP_INSERT, 32'h0, '0, '0, 1'b1));
        pending_requests.push_back(make_req(OP_INSERT, '1, '1, '1, 1'b1));
        pending_requests.push_back(make_req(OP_LOOKUP, 32'h0, '1, '1, 1'b1));
        pending_requests.push_back(make_req(OP_LOOKUP, '1, '0, '0, 1'b0));
        pending_requests.push_back(make_req(OP_UNUSED, '1, '1, '1, 1'b1));
        pending_requests.push_back(make_req(OP_INSERT, 32'h0, 64'h55aa, 32'h7, 1'b0));
        pending_requests.push_back(make_req(OP_LOOKUP, 32'h0, '0, '0, 1'b0));
        pending_requests.push_back(make_req(OP_FLUSH, '1, '1, '1, 1'b1));
        pending_requests.push_back(make_req(OP_LOOKUP, '1, '0, '0, 1'b0));
        // directed: fill the store with slot 5 made inactive, reuse an inactive slot, then insert once more
        for (int k = 0; k < CACHE_ENTRIES; k++)
            pending_requests.push_back(random_req(OP_INSERT, 32'h100 + k));
        pending_requests[pending_requests.size() - 11].entry_active = 1'b0;
        pending_requests.push_back(random_req(OP_INSERT, 32'h200));
        pending_requests.push_back(random_req(OP_INSERT, 32'h201));
        pending_requests.push_back(random_req(OP_LOOKUP, 32'h200));

        // random: runs of inserts, lookups, flushes and unused codes over a small id pool
        rand_count = 0;
        while (rand_count < RANDOM_ITEMS) begin
            if ($urandom_range(0, 3) == 0) begin
                pending_requests.push_back(random_req(OP_FLUSH, $urandom));
                rand_count++;
            end
            pool_size = $urandom_range(1, 24);
            for (int p = 0; p < pool_size; p++) begin
                case ($urandom_range(0, 9))
                    0:       id_pool[p] = '0;
                    1:       id_pool[p] = '1;
                    2:       id_pool[p] = 32'h1000 + p;
                    default: id_pool[p] = $urandom;
                endcase
            end
            run_len = $urandom_range(10, 60);
            for (int j = 0; j < run_len; j++) begin
                pick = $urandom_range(0, 99);
                if (pick < 45)
                    pending_requests.push_back(random_req(OP_INSERT,
                        id_pool[$urandom_range(0, pool_size - 1)]));
                else if (pick < 90)
                    pending_requests.push_back(random_req(OP_LOOKUP,
                        id_pool[$urandom_range(0, pool_size - 1)]));
                else if (pick < 94)
                    pending_requests.push_back(random_req(OP_LOOKUP, $urandom));
                else if (pick < 97)
                    pending_requests.push_back(random_req(OP_FLUSH, $urandom));
                else
                    pending_requests.push_back(random_req(OP_UNUSED, $urandom));
            end
            rand_count += run_len;
        end

        // reset
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // drain: all requests taken and every response seen
        @(posedge i_clk);
        #1;
        while (pending_requests.size() > 0 || start || expected_responses.size() > 0) begin
            @(posedge i_clk);
            #1;
        end
        repeat (8) @(posedge i_clk);
        #1;
        if (expected_responses.size() > 0) begin
            $error("responses still expected at end of run");
            errors++;
        end
        if (errors == 0) begin
            $display("key_cache_table_test: PASS");
        end else begin
            $display("key_cache_table_test: FAIL");
        end
        $finish;
    end

endmodule
